// ----- design/ssmg_pkg.sv -----
// Shared types, constants and the sine table generator for the stepper microstep generator.
package ssmg_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_RPM_Q8  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 4'd1;

    localparam logic [15:0] SPEED_RESET = 16'd2560;
    localparam logic [15:0] STEPS_RESET = 16'd200;

    // 1e9 revolutions in Q31.32
    localparam logic [63:0] RESET_REQUEST = 64'd1_000_000_000 << 32;

    // Serial multiplier: 36-bit operand times 16-bit operand
    localparam int MUL_AW = 36;
    localparam int MUL_BW = 16;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // d = (P << 24) / 60e6 == (P << 16) / (60e6 >> 8); quotient fits 35 bits
    localparam int DIV_XW    = 36;
    localparam int DIV_SHIFT = 16;
    localparam int DIV_QW    = 35;
    localparam int DIV_RW    = 18;
    localparam logic [DIV_RW-1:0] DIV_DEN = 18'd234375;

    // pi/2 in Q30
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef struct packed {
        logic               func;
        logic [19:0]        elapsed_us;
        logic signed [63:0] request_value;
    } in_t;

    typedef struct packed {
        logic [14:0]        duty_a;
        logic               dir_a;
        logic [14:0]        duty_b;
        logic               dir_b;
        logic signed [63:0] remaining_rotation;
        logic signed [63:0] completed_rotation;
        logic [15:0]        electrical_phase;
    } out_t;

    typedef struct packed {
        logic [14:0] sin_mag;
        logic        sin_dir;
        logic [14:0] cos_mag;
        logic        cos_dir;
    } coil_t;

    // Quarter-wave entry: Q30 Taylor series, 9 terms, rounded half up, capped.
    function automatic logic [14:0] sine_entry(input int unsigned idx,
                                               input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] amp;
        int          k;
        x    = (Q30_HALF_PI * 64'(idx)) >> tbits;
        term = x;
        sum  = x;
        for (k = 1; k <= 8; k++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum[63]) begin
            sum = '0;
        end
        amp = (sum * 64'd32767 + 64'd536870912) >> 30;
        if (amp > 64'd32767) begin
            amp = 64'd32767;
        end
        return amp[14:0];
    endfunction

endpackage

// ----- design/ssmg_serial_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
module ssmg_serial_mul import ssmg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MUL_AW-1:0] a,
    input  logic [MUL_BW-1:0] b,
    output logic              done,
    output logic [MUL_PW-1:0] prod
);
    localparam int CNT_W = $clog2(MUL_BW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MUL_AW-1:0] a_reg;
    logic [MUL_AW-1:0] hi_reg;
    logic [MUL_BW-1:0] lo_reg;
    logic [MUL_AW:0]   psum;

    // Add the multiplicand into the upper half when the outgoing bit is set
    assign psum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MUL_BW);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= psum[MUL_AW:1];
            lo_reg <= {psum[0], lo_reg[MUL_BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// ----- design/ssmg_serial_div.sv -----
// Restoring divider by the fixed rate constant, one quotient bit per cycle.
module ssmg_serial_div import ssmg_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_XW-1:0] dividend,
    output logic              done,
    output logic [DIV_QW-1:0] quot
);
    // Leading dividend bits that always stay below the divisor
    localparam int TOP_W = DIV_XW + DIV_SHIFT - DIV_QW;
    localparam int CNT_W = $clog2(DIV_QW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_RW-1:0] rem_reg;
    logic [DIV_QW-1:0] sh_reg;
    logic [DIV_QW-1:0] q_reg;
    logic [DIV_RW:0]   trial;
    logic [DIV_RW:0]   diff;
    logic              ge;

    assign trial = {rem_reg, sh_reg[DIV_QW-1]};
    assign diff  = trial - {1'b0, DIV_DEN};
    assign ge    = trial >= {1'b0, DIV_DEN};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_QW);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIV_RW'(dividend[DIV_XW-1 -: TOP_W]);
            sh_reg  <= {dividend[DIV_XW-TOP_W-1:0], {DIV_SHIFT{1'b0}}};
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
            sh_reg  <= {sh_reg[DIV_QW-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- design/ssmg_sine_lookup.sv -----
// Quarter-wave sine ROM with sequential sine and cosine reads for one phase.
module ssmg_sine_lookup import ssmg_pkg::*; #(
    parameter int PHASE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [PHASE_BITS-1:0] phase,
    output logic                  done,
    output coil_t                 coil
);
    localparam int TBL_N  = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W = SINE_TABLE_BITS + 1;
    localparam int LOW_W  = PHASE_BITS - 2;

    logic [14:0]                sine_rom [TBL_N+1];
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [1:0]                 cnt_reg, cnt_next;
    logic [PHASE_BITS-1:0]      phase_reg;
    logic [14:0]                rom_q_reg;
    logic [14:0]                sin_reg;
    logic [14:0]                cos_reg;
    logic [1:0]                 quad_sin;
    logic [1:0]                 quad_cos;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [ADDR_W-1:0]          addr_sin;
    logic [ADDR_W-1:0]          addr_cos;
    logic [ADDR_W-1:0]          rom_addr;

    for (genvar gi = 0; gi <= TBL_N; gi++) begin : g_rom
        assign sine_rom[gi] = sine_entry(gi, SINE_TABLE_BITS);
    end

    // Fit the in-quadrant bits to the table index width
    if (LOW_W >= SINE_TABLE_BITS) begin : g_trunc
        assign idx = phase_reg[LOW_W-1 -: SINE_TABLE_BITS];
    end else begin : g_widen
        localparam int PAD = SINE_TABLE_BITS - LOW_W;
        assign idx = {phase_reg[LOW_W-1:0], {PAD{1'b0}}};
    end

    // Cosine sits one quadrant ahead with the same in-quadrant bits
    assign quad_sin = phase_reg[PHASE_BITS-1 -: 2];
    assign quad_cos = quad_sin + 2'd1;
    assign addr_sin = quad_sin[0] ? (ADDR_W'(TBL_N) - {1'b0, idx}) : {1'b0, idx};
    assign addr_cos = quad_cos[0] ? (ADDR_W'(TBL_N) - {1'b0, idx}) : {1'b0, idx};
    assign rom_addr = (cnt_reg == 2'd0) ? addr_sin : addr_cos;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd2) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            phase_reg <= phase;
        end
        if (busy_reg) begin
            rom_q_reg <= sine_rom[rom_addr];
        end
        if (busy_reg && cnt_reg == 2'd1) begin
            sin_reg <= rom_q_reg;
        end
        if (busy_reg && cnt_reg == 2'd2) begin
            cos_reg <= rom_q_reg;
        end
    end

    assign done         = done_reg;
    assign coil.sin_mag = sin_reg;
    assign coil.sin_dir = !quad_sin[1] && (sin_reg != '0);
    assign coil.cos_mag = cos_reg;
    assign coil.cos_dir = !quad_cos[1] && (cos_reg != '0);

endmodule

// ----- design/stepper_sine_microstep_generator_unit.sv -----
// Top level of the two-coil sine/cosine microstep generator.
//
// Usage:
//   s_* channel: one beat per update. func = 0 is a time tick carrying elapsed_us;
//   func = 1 loads request_value as the new remaining rotation.
//   m_* channel: exactly one beat per input beat with both coil drives
//   (magnitude plus direction), remaining and completed rotation, and the
//   16-bit electrical phase.
//   cfg_* channel: speed_rpm_q8 (index 0) or steps_per_rev (index 1); always ready.
//   The user writes it only while no update is in flight; the block does not enforce it.
// Sequence:
//   a tick beat runs the bit-serial multiply of speed times time, the bit-serial
//   divide by the rate constant, the multiply by steps_per_rev, the sine and
//   cosine ROM reads and the load of the output register, in that order, and
//   m_valid rises with the load. A load beat runs only the ROM reads and the
//   output load. One update is in flight at a time; s_ready returns when the
//   result is loaded, so a new beat is taken only after the last one is done.
// Reset: phase 0, remaining 1e9 revolutions, completed 0, config at defaults.
// Stall: a result waits in the output register while m_ready is low; the next
//   input beat is still taken and worked on, and its result waits for that slot.
module stepper_sine_microstep_generator_unit import ssmg_pkg::*; #(
    parameter int PHASE_BITS      = 16,
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);
    localparam int D_PAD = 64 - DIV_QW;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL1 = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_MUL2 = 7'b0001000,
        S_LOOK = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_SPARE = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [63:0]           req_reg, req_next;
    logic [63:0]           rot_reg, rot_next;
    logic [15:0]           speed_reg, speed_next;
    logic [15:0]           steps_reg, steps_next;
    logic [DIV_QW-1:0]     d_reg, d_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    logic                  accept;
    logic                  mul_start, mul_done;
    logic [MUL_AW-1:0]     mul_a;
    logic [MUL_BW-1:0]     mul_b;
    logic [MUL_PW-1:0]     mul_prod;
    logic                  div_start, div_done;
    logic [DIV_QW-1:0]     div_quot;
    logic                  look_start, look_done;
    coil_t                 coil;
    logic [63:0]           mag;
    logic [DIV_QW-1:0]     d_clamp;
    logic [63:0]           d_wide;
    logic [PHASE_BITS-1:0] step;
    logic [63:0]           rot_sum;
    logic [63:0]           rot_dif;
    logic                  upd_fire;
    logic [15:0]           ephase;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Clamp the increment to the magnitude of the remaining request
    assign mag     = req_reg[63] ? (64'd0 - req_reg) : req_reg;
    assign d_clamp = ({{D_PAD{1'b0}}, div_quot} > mag) ? mag[DIV_QW-1:0] : div_quot;
    assign d_wide  = {{D_PAD{1'b0}}, d_reg};
    assign step    = mul_prod[33 -: PHASE_BITS];
    assign rot_sum = rot_reg + d_wide;
    assign rot_dif = rot_reg - d_wide;
    assign upd_fire = (state_reg == S_MUL2) && mul_done;

    // The serial multiplier serves speed * time first, then increment * steps
    assign mul_a = (state_reg == S_IDLE) ? MUL_AW'(s_data.elapsed_us) : MUL_AW'(d_clamp);
    assign mul_b = (state_reg == S_IDLE) ? speed_reg : steps_reg;

    if (PHASE_BITS >= 16) begin : g_ph_trunc
        assign ephase = phase_reg[PHASE_BITS-1 -: 16];
    end else begin : g_ph_widen
        assign ephase = {phase_reg, {(16 - PHASE_BITS){1'b0}}};
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        req_next     = req_reg;
        rot_next     = rot_reg;
        speed_next   = speed_reg;
        steps_next   = steps_reg;
        d_next       = d_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        look_start   = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_SPEED_RPM_Q8:  speed_next = cfg_data;
                CFG_STEPS_PER_REV: steps_next = cfg_data;
                default: ;
            endcase
        end

        // Drop the held result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.func) begin
                        req_next   = s_data.request_value;
                        look_start = 1'b1;
                        state_next = S_LOOK;
                    end else begin
                        mul_start  = 1'b1;
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    d_next     = d_clamp;
                    mul_start  = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2: begin
                if (mul_done) begin
                    // Move the increment from remaining to completed, saturating
                    if (req_reg[63]) begin
                        req_next   = req_reg + d_wide;
                        rot_next   = (rot_reg[63] && !rot_dif[63]) ? {1'b1, 63'd0} : rot_dif;
                        phase_next = phase_reg - step;
                    end else begin
                        req_next   = req_reg - d_wide;
                        rot_next   = (!rot_reg[63] && rot_sum[63]) ? {1'b0, {63{1'b1}}} : rot_sum;
                        phase_next = phase_reg + step;
                    end
                    look_start = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                if (look_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                // Hold until the output slot is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                   = 1'b1;
                    m_data_next.duty_a             = coil.sin_mag;
                    m_data_next.dir_a              = coil.sin_dir;
                    m_data_next.duty_b             = coil.cos_mag;
                    m_data_next.dir_b              = coil.cos_dir;
                    m_data_next.remaining_rotation = req_reg;
                    m_data_next.completed_rotation = rot_reg;
                    m_data_next.electrical_phase   = ephase;
                    state_next                     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= '0;
            req_reg     <= RESET_REQUEST;
            rot_reg     <= '0;
            speed_reg   <= SPEED_RESET;
            steps_reg   <= STEPS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            req_reg     <= req_next;
            rot_reg     <= rot_next;
            speed_reg   <= speed_next;
            steps_reg   <= steps_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg      <= d_next;
        m_data_reg <= m_data_next;
    end

    ssmg_serial_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .a        (mul_a),
        .b        (mul_b),
        .done     (mul_done),
        .prod     (mul_prod)
    );

    ssmg_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_prod[DIV_XW-1:0]),
        .done     (div_done),
        .quot     (div_quot)
    );

    ssmg_sine_lookup #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_lookup (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (look_start),
        .phase    (phase_next),
        .done     (look_done),
        .coil     (coil)
    );

    // A tick beat always starts the rate multiply
    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_data.func |=> state_reg == S_MUL1)
        else $error("tick beat did not enter the multiply");

    // Multiplier and divider finish only in the states that wait for them
    a_mul_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_MUL1) || (state_reg == S_MUL2))
        else $error("multiplier finished outside a multiply state");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // The clamped increment never exceeds what is left
    a_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL2 |-> ({{D_PAD{1'b0}}, d_reg} <= mag))
        else $error("increment exceeds remaining rotation");

    // Moving rotation never flips the sign of the remaining request
    a_sign_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_fire |=> (req_reg[63] == $past(req_reg[63])) || (req_reg == '0))
        else $error("remaining rotation changed sign on a tick");

endmodule
